// File: src/oimw_pkg.sv
// ----------------------------------------------------------------------------
// oimw_pkg
// Types and constants shared by the weighted interval merger: item formats,
// the queued operation format and the divider lane control group.
// ----------------------------------------------------------------------------
package oimw_pkg;

  localparam int CHROM_W    = 8;
  localparam int POS_W      = 31;
  localparam int DEPTH_W    = 24;
  localparam int NUM_DEPTHS = 6;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  typedef logic [1:0] hap_t;
  localparam hap_t HAP_RESET = 2'd1;

  // depth slot order: unk, hap1, hap2, hq unk, hq hap1, hq hap2
  localparam int D_UNK     = 0;
  localparam int D_HAP1    = 1;
  localparam int D_HAP2    = 2;
  localparam int D_HQ_UNK  = 3;
  localparam int D_HQ_HAP1 = 4;
  localparam int D_HQ_HAP2 = 5;

  typedef logic [1:0] op_kind_t;
  localparam op_kind_t OP_MERGE = 2'd0;
  localparam op_kind_t OP_LOAD  = 2'd1;
  localparam op_kind_t OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [CHROM_W-1:0] chrom_id;
    logic [POS_W-1:0]   bin_start;
    logic [POS_W-1:0]   bin_end;
    logic [1:0]         del_flags;
    logic [DEPTH_W-1:0] depth_unk;
    logic [DEPTH_W-1:0] depth_hap1;
    logic [DEPTH_W-1:0] depth_hap2;
    logic [DEPTH_W-1:0] hq_depth_unk;
    logic [DEPTH_W-1:0] hq_depth_hap1;
    logic [DEPTH_W-1:0] hq_depth_hap2;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [CHROM_W-1:0] out_chrom;
    logic [POS_W-1:0]   out_start;
    logic [POS_W-1:0]   out_end;
    logic [DEPTH_W-1:0] out_depth_unk;
    logic [DEPTH_W-1:0] out_depth_hap1;
    logic [DEPTH_W-1:0] out_depth_hap2;
    logic [DEPTH_W-1:0] out_hq_unk;
    logic [DEPTH_W-1:0] out_hq_hap1;
    logic [DEPTH_W-1:0] out_hq_hap2;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    op_kind_t                            kind;
    logic                                emit_prev;
    logic                                flush;
    logic [CHROM_W-1:0]                  chrom;
    logic [POS_W-1:0]                    bin_start;
    logic [POS_W-1:0]                    bin_end;
    logic [NUM_DEPTHS-1:0][DEPTH_W-1:0]  depths;
  } op_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic div_en;
  } lane_ctrl_t;

endpackage

// File: src/oimw_front.sv
// ----------------------------------------------------------------------------
// oimw_front
// Accepts input items, filters them by haplotype selection and chromosome
// range, classifies each kept item as merge or load against a shadow of
// the held interval's chromosome and end; a last item can also queue a flush.
// ----------------------------------------------------------------------------
module oimw_front #(
  parameter int CHROM_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  oimw_pkg::in_item_t item_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  oimw_pkg::hap_t    cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output oimw_pkg::op_t     q_op
);
  import oimw_pkg::*;

  localparam logic [16:0] CHROM_LIM = 17'(CHROM_COUNT);

  hap_t               hap_select;
  logic               sh_valid;
  logic [CHROM_W-1:0] sh_chrom;
  logic [POS_W-1:0]   sh_end;

  logic fire, kept, merge, load, flush;

  assign item_ready = !q_full;
  assign cfg_ready  = 1'b1;
  assign fire       = item_valid && item_ready;

  always_comb begin
    kept  = ((item_data.del_flags & hap_select) != 2'd0) &&
            (17'(item_data.chrom_id) < CHROM_LIM);
    merge = kept && sh_valid && (item_data.chrom_id == sh_chrom) &&
            (item_data.bin_start <= sh_end);
    load  = kept && !merge;
    flush = item_data.last_in && (sh_valid || kept);
  end

  assign q_push = fire && (kept || flush);

  always_comb begin
    q_op.kind      = merge ? OP_MERGE : (load ? OP_LOAD : OP_FLUSH);
    q_op.emit_prev = load && sh_valid;
    q_op.flush     = flush;
    q_op.chrom     = item_data.chrom_id;
    q_op.bin_start = item_data.bin_start;
    q_op.bin_end   = item_data.bin_end;
    q_op.depths[D_UNK]     = item_data.depth_unk;
    q_op.depths[D_HAP1]    = item_data.depth_hap1;
    q_op.depths[D_HAP2]    = item_data.depth_hap2;
    q_op.depths[D_HQ_UNK]  = item_data.hq_depth_unk;
    q_op.depths[D_HQ_HAP1] = item_data.hq_depth_hap1;
    q_op.depths[D_HQ_HAP2] = item_data.hq_depth_hap2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hap_select <= HAP_RESET;
      sh_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        hap_select <= cfg_data;
      end
      if (fire) begin
        if (item_data.last_in) begin
          sh_valid <= 1'b0;
        end else if (load) begin
          sh_valid <= 1'b1;
        end
      end
    end
  end

  // shadow of the held chromosome and end, only read while sh_valid
  always_ff @(posedge clk) begin
    if (fire && load) begin
      sh_chrom <= item_data.chrom_id;
      sh_end   <= item_data.bin_end;
    end else if (fire && merge) begin
      sh_end <= item_data.bin_end;
    end
  end

endmodule

// File: src/oimw_queue.sv
// ----------------------------------------------------------------------------
// oimw_queue
// Short first-in first-out queue of classified operations between the
// front and the back.
// ----------------------------------------------------------------------------
module oimw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  oimw_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output oimw_pkg::op_t pop_op
);
  import oimw_pkg::*;

  op_t             entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_op  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == (Q_AW+1)'(Q_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: src/oimw_lane.sv
// ----------------------------------------------------------------------------
// oimw_lane
// One depth lane: two products, their sum, a saturation check and a
// restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module oimw_lane #(
  parameter int DEPTH_BITS = 24
) (
  input  logic                   clk,
  input  oimw_pkg::lane_ctrl_t   ctrl,
  input  logic [DEPTH_BITS-1:0]  held_depth,
  input  logic [DEPTH_BITS-1:0]  bin_depth,
  input  logic [30:0]            held_len,
  input  logic [30:0]            bin_len,
  input  logic [30:0]            span,
  output logic [DEPTH_BITS-1:0]  result
);
  import oimw_pkg::*;

  localparam int PW = DEPTH_BITS + POS_W;
  localparam int NW = PW + 1;

  logic [PW-1:0]         p_held;
  logic [PW-1:0]         p_bin;
  logic [NW-1:0]         num;
  logic [NW-1:0]         limit;
  logic [POS_W-1:0]      rem;
  logic [DEPTH_BITS-1:0] quo;
  logic                  sat;
  logic [POS_W:0]        cand;
  logic                  take;

  always_comb begin
    num   = NW'(p_held) + NW'(p_bin);
    // quotient overflows the depth range exactly when num >= span << DEPTH_BITS
    limit = NW'({span, {DEPTH_BITS{1'b0}}});
    cand  = {rem, quo[DEPTH_BITS-1]};
    take  = (cand >= {1'b0, span});
  end

  assign result = sat ? {DEPTH_BITS{1'b1}} : quo;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_held <= PW'(held_depth) * PW'(held_len);
      p_bin  <= PW'(bin_depth) * PW'(bin_len);
    end
    if (ctrl.add_en) begin
      sat <= (num >= limit);
      rem <= num[DEPTH_BITS +: POS_W];
      quo <= num[DEPTH_BITS-1:0];
    end else if (ctrl.div_en) begin
      rem <= take ? POS_W'(cand - {1'b0, span}) : cand[POS_W-1:0];
      quo <= {quo[DEPTH_BITS-2:0], take};
    end
  end

endmodule

// File: src/oimw_back.sv
// ----------------------------------------------------------------------------
// oimw_back
// Holds the open interval, carries out queued merge, load and flush
// operations, and drives the result register.
// ----------------------------------------------------------------------------
module oimw_back #(
  parameter int DEPTH_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  oimw_pkg::op_t      q_op,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output oimw_pkg::out_item_t res_data
);
  import oimw_pkg::*;

  localparam int CNT_W = $clog2(DEPTH_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;
  localparam logic [2:0] S_LAST = 3'd7;

  function automatic logic [POS_W-1:0] span_of(logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    return (e > s) ? POS_W'(e - s) : '0;
  endfunction

  logic [2:0]            state;
  logic [2:0]            state_next;
  op_t                   op_r;
  logic [CNT_W-1:0]      cnt;
  logic [POS_W-1:0]      held_len;
  logic [POS_W-1:0]      bin_len;
  logic [POS_W-1:0]      span;
  logic [CHROM_W-1:0]    held_chrom;
  logic [POS_W-1:0]      held_start;
  logic [POS_W-1:0]      held_end;
  logic [DEPTH_BITS-1:0] held_depths [NUM_DEPTHS];
  logic [DEPTH_BITS-1:0] lane_q      [NUM_DEPTHS];
  lane_ctrl_t            lctrl;
  logic                  out_free;
  logic                  emit;
  logic                  emit_last;

  assign out_free  = !res_valid || res_ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign emit_last = (state == S_LAST) && op_r.flush && out_free;
  assign emit      = ((state == S_EMIT) && out_free) || emit_last;

  always_comb begin
    lctrl.mul_en = (state == S_MUL);
    lctrl.add_en = (state == S_ADD);
    lctrl.div_en = (state == S_DIV);
  end

  for (genvar i = 0; i < NUM_DEPTHS; i++) begin : g_lane
    oimw_lane #(
      .DEPTH_BITS(DEPTH_BITS)
    ) u_lane (
      .clk       (clk),
      .ctrl      (lctrl),
      .held_depth(held_depths[i]),
      .bin_depth (DEPTH_BITS'(op_r.depths[i])),
      .held_len  (held_len),
      .bin_len   (bin_len),
      .span      (span),
      .result    (lane_q[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_MERGE: state_next = S_MUL;
            OP_LOAD:  state_next = q_op.emit_prev ? S_EMIT : S_LOAD;
            default:  state_next = S_LAST;
          endcase
        end
      end
      S_MUL:  state_next = (span == '0) ? S_LAST : S_ADD;
      S_ADD:  state_next = S_DIV;
      S_DIV:  state_next = (cnt == CNT_W'(DEPTH_BITS-1)) ? S_WB : S_DIV;
      S_WB:   state_next = S_LAST;
      S_EMIT: state_next = out_free ? S_LOAD : S_EMIT;
      S_LOAD: state_next = S_LAST;
      S_LAST: state_next = (!op_r.flush || out_free) ? S_IDLE : S_LAST;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r     <= q_op;
      held_len <= span_of(held_start, held_end);
      bin_len  <= span_of(q_op.bin_start, q_op.bin_end);
      span     <= span_of(held_start, q_op.bin_end);
    end
    if (state == S_ADD) begin
      cnt <= '0;
    end else if (state == S_DIV) begin
      cnt <= cnt + 1'b1;
    end
    // a zero span moves the end and leaves the depths alone
    if ((state == S_MUL && span == '0) || state == S_WB) begin
      held_end <= op_r.bin_end;
    end
    if (state == S_WB) begin
      for (int i = 0; i < NUM_DEPTHS; i++) begin
        held_depths[i] <= lane_q[i];
      end
    end
    if (state == S_LOAD) begin
      held_chrom <= op_r.chrom;
      held_start <= op_r.bin_start;
      held_end   <= op_r.bin_end;
      for (int i = 0; i < NUM_DEPTHS; i++) begin
        held_depths[i] <= DEPTH_BITS'(op_r.depths[i]);
      end
    end
    if (emit) begin
      res_data.out_chrom      <= held_chrom;
      res_data.out_start      <= held_start;
      res_data.out_end        <= held_end;
      res_data.out_depth_unk  <= DEPTH_W'(held_depths[D_UNK]);
      res_data.out_depth_hap1 <= DEPTH_W'(held_depths[D_HAP1]);
      res_data.out_depth_hap2 <= DEPTH_W'(held_depths[D_HAP2]);
      res_data.out_hq_unk     <= DEPTH_W'(held_depths[D_HQ_UNK]);
      res_data.out_hq_hap1    <= DEPTH_W'(held_depths[D_HQ_HAP1]);
      res_data.out_hq_hap2    <= DEPTH_W'(held_depths[D_HQ_HAP2]);
      res_data.out_last       <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD || state == S_DIV) |-> span != '0)
    else $error("divider running with zero span");
  a_mul_is_merge: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> op_r.kind == OP_MERGE)
    else $error("multiply step on a non-merge operation");
  a_emit_is_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (op_r.kind == OP_LOAD && op_r.emit_prev))
    else $error("emit of previous interval without a load");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> $past(state) == S_DIV && $past(cnt) == CNT_W'(DEPTH_BITS-1))
    else $error("write-back before all quotient bits");
`endif

endmodule

// File: src/overlap_interval_merger_weighted_unit.sv
// ----------------------------------------------------------------------------
// overlap_interval_merger_weighted_unit
// Weighted merger of overlapping sorted genomic bins for one haplotype pass.
// ----------------------------------------------------------------------------
// a merging item steps through the multiply, add, divide, write-back and last
//   states of the back, with one-bit-per-cycle restoring dividers in six lanes
// a load steps through load and last, after emit when it first sends the held
//   interval; an empty-span merge skips to last; a flush emits in the last state
// the front accepts an item per cycle while the 4-entry queue has room
// synchronous reset: nothing held, queue empty, no result pending, hap_select 1
module overlap_interval_merger_weighted_unit #(
  parameter int CHROM_COUNT = 256,
  parameter int DEPTH_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  oimw_pkg::in_item_t  item_data,
  output logic                res_valid,
  input  logic                res_ready,
  output oimw_pkg::out_item_t res_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  oimw_pkg::hap_t      cfg_data
);
  import oimw_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  op_t  push_op, pop_op;

  oimw_front #(
    .CHROM_COUNT(CHROM_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item_data (item_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  oimw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .pop_op (pop_op)
  );

  oimw_back #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (pop_op),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

endmodule
